>>> design/tjts_pkg.sv
// ----------------------------------------------------------------------------
// tjts_pkg: shared types and constants for the timed job table scheduler
// Register indexes, result codes, sequencer states and divider request/response layouts.
// ----------------------------------------------------------------------------
package tjts_pkg;

    localparam int SLOTS    = 8;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IN_W     = 144;
    localparam int OUT_W    = 112;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 2'd3;

    localparam logic [1:0] RK_FIRED    = 2'd0;
    localparam logic [1:0] RK_DIRECT   = 2'd1;
    localparam logic [1:0] RK_WAKE     = 2'd2;
    localparam logic [1:0] RK_ACCEPTED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_DIV,
        ST_MOD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [41:0] dividend;
        logic [10:0] divisor;
        logic        mod;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [41:0] quot;
        logic [15:0] rem;
    } t_div_rsp;

endpackage

>>> design/timed_job_table_scheduler_unit.sv
// ----------------------------------------------------------------------------
// timed_job_table_scheduler_unit: timed job table with tick scan
// Slot table, one shared subtract/compare pass per slot and a shared divider.
// ----------------------------------------------------------------------------
// Input items on s_axis: tuser is kind (0 schedule, 1 tick). Each schedule
// item gives one result (direct run, accepted, or exhausted direct run).
// Each tick item walks the slots from highest to lowest, one slot per cycle
// while m_axis does not stall, with an emit step per due job giving a fired
// result, then one wake summary with tlast. Results leave on m_axis from an
// output register; tuser is result_kind. A schedule result is valid the cycle
// after the item is taken. If jobs remain, the divider does the tick conversion
// and, with a nonzero timer_top, the modulo; then the summary is loaded. One
// item is worked on at a time; s_axis_tready is low until the last result of
// the item is taken. A stall on m_axis holds the result and the scan, emit and
// summary steps. Reset clears slot valid bits and loads register defaults:
// ticks_per_us 16, prescaler 64, timer_top 65535, direct_threshold 1000.
// Config writes go through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// make them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module timed_job_table_scheduler_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tjts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tjts_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // handler[7:0], tag[23:8], start_time[55:24], delay_us[87:56],
    // now_us[119:88], timer_count[135:120], zero pad
    input  logic [tjts_pkg::IN_W-1:0]         s_axis_tdata,
    // kind
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_handler[7:0], out_tag[23:8], due_time[55:24], overshoot_us[87:56],
    // exhausted[88], wake_pending[89], compare_value[105:90], zero pad
    output logic [tjts_pkg::OUT_W-1:0]        m_axis_tdata,
    // result_kind
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);
    import tjts_pkg::*;

    logic [7:0]  r_ticks;
    logic [10:0] r_presc;
    logic [15:0] r_top;
    logic [15:0] r_thresh;

    logic [SLOTS-1:0] r_used, n_used;
    logic [7:0]  r_sh [SLOTS];
    logic [15:0] r_stag [SLOTS];
    logic [31:0] r_sstart [SLOTS];
    logic [31:0] r_sdelay [SLOTS];

    t_state r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic        r_have, n_have;
    logic [31:0] r_low, n_low;
    logic [31:0] r_now;
    logic [15:0] r_cnt;

    logic              r_ov, n_ov;
    logic [1:0]        r_rk, n_rk;
    logic [OUT_W-1:0]  r_od, n_od;
    logic              r_ol, n_ol;

    logic              w_wr;
    logic [SLOT_W-1:0] w_free;
    logic              w_has_free;
    logic [31:0]       w_el, w_rem, w_over;
    logic              w_due;
    logic [15:0]       w_capped, w_sum;
    logic              w_first;
    t_div_req          w_req;
    t_div_rsp          w_rsp;

    tjts_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    logic [7:0]  w_h;
    logic [15:0] w_t;
    logic [31:0] w_s, w_d;
    assign w_h = s_axis_tdata[7:0];
    assign w_t = s_axis_tdata[23:8];
    assign w_s = s_axis_tdata[55:24];
    assign w_d = s_axis_tdata[87:56];

    always_comb begin
        w_free = '0;
        w_has_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free = SLOT_W'(i);
                w_has_free = 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ov;
    assign w_el   = r_now - r_sstart[r_idx];
    assign w_due  = w_el >= r_sdelay[r_idx];
    assign w_rem  = r_sdelay[r_idx] - w_el;
    assign w_over = w_el - r_sdelay[r_idx];
    assign w_first = (r_idx == SLOT_W'(0));
    assign w_capped = (|w_rsp.quot[41:16] || w_rsp.quot[15:0] > r_top)
                      ? r_top : w_rsp.quot[15:0];
    assign w_sum = w_capped + r_cnt;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready && s_axis_tuser)
                n_state = ST_SCAN;
            ST_SCAN: if (!r_ov || m_axis_tready) begin
                if (r_used[r_idx] && w_due) n_state = ST_EMIT;
                else if (w_first) n_state = (r_have || r_used[r_idx]) ? ST_DIV : ST_OUT;
            end
            ST_EMIT: n_state = (w_first) ? ((r_have) ? ST_DIV : ST_OUT) : ST_SCAN;
            ST_DIV:  if (w_rsp.done) n_state = (r_top != 16'd0) ? ST_MOD : ST_OUT;
            ST_MOD:  if (w_rsp.done) n_state = ST_OUT;
            ST_OUT:  if (!r_ov || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_idx  = r_idx;
        n_have = r_have;
        n_low  = r_low;
        n_used = r_used;
        n_ov   = r_ov && !m_axis_tready;
        n_rk   = r_rk;
        n_od   = r_od;
        n_ol   = r_ol;
        w_wr   = 1'b0;
        w_req  = '0;
        case (r_state)
            ST_IDLE: begin
                n_idx  = SLOT_W'(SLOTS - 1);
                n_have = 1'b0;
                if (s_axis_tvalid && s_axis_tready && !s_axis_tuser) begin
                    n_ov = 1'b1;
                    n_ol = 1'b1;
                    n_od = '0;
                    n_od[55:0] = {w_s + w_d, w_t, w_h};
                    if (w_d < {16'd0, r_thresh}) begin
                        n_rk = RK_DIRECT;
                    end else if (w_has_free) begin
                        n_rk = RK_ACCEPTED;
                        w_wr = 1'b1;
                        n_used[w_free] = 1'b1;
                    end else begin
                        n_rk = RK_DIRECT;
                        n_od[88] = 1'b1;
                    end
                end
            end
            ST_SCAN: if (!r_ov || m_axis_tready) begin
                if (r_used[r_idx] && !w_due && (!r_have || w_rem < r_low)) begin
                    n_low  = w_rem;
                    n_have = 1'b1;
                end
                if (!(r_used[r_idx] && w_due) && !w_first) n_idx = r_idx - SLOT_W'(1);
                if (w_first && !(r_used[r_idx] && w_due) &&
                    (r_have || r_used[r_idx])) begin
                    w_req.start = 1'b1;
                    w_req.dividend = 42'((r_used[r_idx] && (!r_have || w_rem < r_low))
                                         ? w_rem : r_low) * 42'(r_ticks);
                    w_req.divisor = (r_presc == 11'd0) ? 11'd1 : r_presc;
                end
            end
            ST_EMIT: if (!r_ov || m_axis_tready) begin
                n_used[r_idx] = 1'b0;
                n_ov = 1'b1;
                n_ol = 1'b0;
                n_rk = RK_FIRED;
                n_od = '0;
                n_od[87:0] = {w_over, r_sstart[r_idx] + r_sdelay[r_idx],
                              r_stag[r_idx], r_sh[r_idx]};
                if (!w_first) n_idx = r_idx - SLOT_W'(1);
                if (w_first && r_have) begin
                    w_req.start = 1'b1;
                    w_req.dividend = 42'(r_low) * 42'(r_ticks);
                    w_req.divisor = (r_presc == 11'd0) ? 11'd1 : r_presc;
                end
            end
            ST_DIV: if (w_rsp.done) begin
                n_low = {16'd0, w_sum};
                if (r_top != 16'd0) begin
                    w_req.start = 1'b1;
                    w_req.mod = 1'b1;
                    w_req.dividend = {r_top, 10'd0, w_sum};
                end
            end
            ST_MOD: if (w_rsp.done) n_low = {16'd0, w_rsp.rem};
            ST_OUT: if (!r_ov || m_axis_tready) begin
                n_ov = 1'b1;
                n_ol = 1'b1;
                n_rk = RK_WAKE;
                n_od = '0;
                n_od[89] = r_have;
                n_od[105:90] = r_have ? r_low[15:0] : 16'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_ov     <= 1'b0;
            r_ticks  <= 8'd16;
            r_presc  <= 11'd64;
            r_top    <= 16'hFFFF;
            r_thresh <= 16'd1000;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TICKS:     r_ticks  <= i_cfg_data[7:0];
                    REG_PRESCALER: r_presc  <= i_cfg_data[10:0];
                    REG_TOP:       r_top    <= i_cfg_data;
                    REG_THRESH:    r_thresh <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_idx  <= n_idx;
        r_have <= n_have;
        r_low  <= n_low;
        r_rk   <= n_rk;
        r_od   <= n_od;
        r_ol   <= n_ol;
        if (s_axis_tvalid && s_axis_tready) begin
            r_now <= s_axis_tdata[119:88];
            r_cnt <= s_axis_tdata[135:120];
        end
        if (w_wr) begin
            r_sh[w_free]     <= w_h;
            r_stag[w_free]   <= w_t;
            r_sstart[w_free] <= w_s;
            r_sdelay[w_free] <= w_d;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_rk;
    assign m_axis_tlast  = r_ol;
endmodule

>>> design/tjts_divider.sv
// ----------------------------------------------------------------------------
// tjts_divider: shared restoring divider
// One quotient bit per cycle; serves the tick conversion and the modulo.
// ----------------------------------------------------------------------------
module tjts_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tjts_pkg::t_div_req i_req,
    output tjts_pkg::t_div_rsp o_rsp
);
    import tjts_pkg::*;

    logic [41:0] r_quot, n_quot;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_div, n_div;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [17:0] w_sh;
    logic [17:0] w_sub;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem, r_quot[41]};
        w_sub  = w_sh - {1'b0, r_div};
        if (i_req.start) begin
            n_quot = i_req.mod ? {i_req.dividend[15:0], 26'd0} : i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.mod ? {1'b0, i_req.dividend[41:26]}
                               : {6'd0, i_req.divisor};
            n_cnt  = i_req.mod ? 6'd16 : 6'd42;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[17]) begin
                n_rem  = w_sub[16:0];
                n_quot = {r_quot[40:0], 1'b1};
            end else begin
                n_rem  = w_sh[16:0];
                n_quot = {r_quot[40:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[15:0];
endmodule
